[sv/gf2_128_evaluation_hash_unit_assert.svh]
// Assertion macros for the polynomial evaluation hash unit.
`ifndef GF2_128_EVALUATION_HASH_UNIT_ASSERT_SVH
`define GF2_128_EVALUATION_HASH_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define GFEH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define GFEH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

[sv/gfeh_pkg.sv]
// Types and constants for the polynomial evaluation hash unit.
package gfeh_pkg;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_WAIT
  } state_t;

  localparam logic [1:0]  CFG_KEY_HIGH   = 2'd0;
  localparam logic [1:0]  CFG_KEY_LOW    = 2'd1;
  localparam logic [1:0]  CFG_POLY_LOW   = 2'd2;

  localparam logic [15:0] POLY_LOW_RESET = 16'h0087;

endpackage

[sv/gf2_128_evaluation_hash_unit.sv]
// Polynomial evaluation hash over GF(2^n): tag = (tag ^ block) * key mod f(x).
// Each word passes through NDIG multiply digits, NDIG = FIELD_BITS / DIGIT_BITS
// rounded up (16 at defaults); one key digit per cycle through the shared multiply step.
// A new word is taken only when idle; a stalled result holds the unit until it leaves.
// Reset (synchronous, rst_n low): accumulator and keys cleared, poly to 0x87, output empty.
`include "gf2_128_evaluation_hash_unit_assert.svh"

module gf2_128_evaluation_hash_unit #(
  parameter int FIELD_BITS = 128,
  parameter int DIGIT_BITS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  // config write port
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [63:0]  cfg_wdata,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // [63:0] block_high, [127:64] block_low
  input  logic         in_tlast,   // last_block
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // [63:0] tag_high, [127:64] tag_low
  output logic         out_tlast   // tag_final
);

  localparam int NDIG = (FIELD_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int PADW = NDIG * DIGIT_BITS;
  localparam int CNTW = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam logic [CNTW-1:0] DIG_TOP = CNTW'(NDIG - 1);

  gfeh_pkg::state_t state_r, state_nxt;

  logic [63:0]           key_hi_r;
  logic [63:0]           key_lo_r;
  logic [15:0]           poly_r;
  logic [FIELD_BITS-1:0] acc_r;
  logic [FIELD_BITS-1:0] a_r;
  logic [FIELD_BITS-1:0] r_r;
  logic [CNTW-1:0]       dig_r;
  logic                  last_r;
  logic [127:0]          out_tdata_r;
  logic                  out_tlast_r;
  logic                  out_tvalid_r;

  logic [127:0]          key_full;
  logic [127:0]          blk_full;
  logic [PADW-1:0]       key_pad;
  logic [DIGIT_BITS-1:0] digit;
  logic [FIELD_BITS-1:0] step;
  logic [127:0]          res_full;
  logic                  slot_free;
  logic                  accept;

  assign key_full  = {key_hi_r, key_lo_r};
  assign blk_full  = {in_tdata[63:0], in_tdata[127:64]};
  assign key_pad   = PADW'(key_full[FIELD_BITS-1:0]);
  assign digit     = key_pad[dig_r * DIGIT_BITS +: DIGIT_BITS];
  assign slot_free = !out_tvalid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign in_tready  = (state_r == gfeh_pkg::S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  // One digit of the shift-and-add multiply: r = r * x^D + a * digit, reduced.
  always_comb begin
    logic top;
    step = r_r;
    for (int k = DIGIT_BITS - 1; k >= 0; k--) begin
      top  = step[FIELD_BITS-1];
      step = step << 1;
      if (top) begin
        step[15:0] = step[15:0] ^ poly_r;
      end
      if (digit[k]) begin
        step = step ^ a_r;
      end
    end
  end

  // Final tag comes from the step on the last digit, or from r_r when held back.
  always_comb begin
    if (state_r == gfeh_pkg::S_WAIT) begin
      res_full = 128'(r_r);
    end else begin
      res_full = 128'(step);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gfeh_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = gfeh_pkg::S_MUL;
        end
      end
      gfeh_pkg::S_MUL: begin
        if (dig_r == '0) begin
          state_nxt = slot_free ? gfeh_pkg::S_IDLE : gfeh_pkg::S_WAIT;
        end
      end
      gfeh_pkg::S_WAIT: begin
        if (slot_free) begin
          state_nxt = gfeh_pkg::S_IDLE;
        end
      end
      default: state_nxt = gfeh_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gfeh_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
      poly_r   <= gfeh_pkg::POLY_LOW_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        gfeh_pkg::CFG_KEY_HIGH: key_hi_r <= cfg_wdata;
        gfeh_pkg::CFG_KEY_LOW:  key_lo_r <= cfg_wdata;
        gfeh_pkg::CFG_POLY_LOW: poly_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  logic done;
  assign done = ((state_r == gfeh_pkg::S_MUL) && (dig_r == '0) && slot_free) ||
                ((state_r == gfeh_pkg::S_WAIT) && slot_free);

  // Datapath and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (done) begin
        out_tvalid_r <= 1'b1;
        acc_r        <= last_r ? '0 : res_full[FIELD_BITS-1:0];
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_r    <= acc_r ^ blk_full[FIELD_BITS-1:0];
      r_r    <= '0;
      dig_r  <= DIG_TOP;
      last_r <= in_tlast;
    end else if (state_r == gfeh_pkg::S_MUL) begin
      r_r   <= step;
      dig_r <= dig_r - 1'b1;
    end
    if (done) begin
      out_tdata_r <= {res_full[63:0], res_full[127:64]};
      out_tlast_r <= last_r;
    end
  end

  `GFEH_ASSERT_NXT(a_start, accept, (state_r == gfeh_pkg::S_MUL) && (dig_r == DIG_TOP))
  `GFEH_ASSERT_IMP(a_wait_full, state_r == gfeh_pkg::S_WAIT, out_tvalid_r)
  `GFEH_ASSERT_NXT(a_finish, (state_r == gfeh_pkg::S_MUL) && (dig_r == '0) && slot_free,
                   (state_r == gfeh_pkg::S_IDLE) && out_tvalid_r)
  `GFEH_ASSERT_IMP(a_final_clears, out_tvalid_r && out_tlast_r, acc_r == '0)

endmodule
